[rtl/core/text_cell_glyph_renderer_macros.svh]
// Assertion macros for the text cell glyph renderer RTL.
// Used by files that carry concurrent checks; no dependencies.
`ifndef TEXT_CELL_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CELL_GLYPH_RENDERER_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is high
`define TCGR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tcgr check failed");
// clocked check that also holds during reset
`define TCGR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcgr check failed");
`else
`define TCGR_ASSERT(lbl, clk, rst, prop)
`define TCGR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/core/tcgr_pkg.sv]
// Shared types, constants and tables for the text cell glyph renderer.
// No dependencies.
package tcgr_pkg;

  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 16;

  // pixel counter within a glyph line
  localparam int K_W = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  // row * GLYPH_HEIGHT + line
  localparam int RL_W = 8 + $clog2(GLYPH_HEIGHT) + 1;
  // scan line base offset, rl * pitch
  localparam int LB_W = RL_W + 16;
  // col * GLYPH_WIDTH, then times bytes per pixel
  localparam int COL_W = 8 + $clog2(GLYPH_WIDTH) + 1;
  localparam int CO_W  = COL_W + 3;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_LINE_PITCH   = 3'd1,
    REG_RED_SIZE     = 3'd2,
    REG_RED_POS      = 3'd3,
    REG_GREEN_SIZE   = 3'd4,
    REG_GREEN_POS    = 3'd5,
    REG_BLUE_SIZE    = 3'd6,
    REG_BLUE_POS     = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FMT_8BPP  = 2'd0,
    FMT_16BPP = 2'd1,
    FMT_24BPP = 2'd2,
    FMT_32BPP = 2'd3
  } pixel_fmt_t;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic [15:0] line_pitch;
    logic [3:0]  red_size;
    logic [4:0]  red_pos;
    logic [3:0]  green_size;
    logic [4:0]  green_pos;
    logic [3:0]  blue_size;
    logic [4:0]  blue_pos;
  } cfg_t;

  // one prepared glyph line, handed from prep to the emitter
  typedef struct packed {
    logic [LB_W-1:0]        line_base;
    logic [CO_W-1:0]        col_off;
    logic [2:0]             bpp;
    logic [31:0]            fg_val;
    logic [31:0]            bg_val;
    logic [GLYPH_WIDTH-1:0] on;
  } job_t;

  // 16-entry text palette, red in 23:16, green 15:8, blue 7:0
  function automatic logic [23:0] palette(logic [3:0] idx);
    logic [23:0] e;
    unique case (idx)
      4'd0:  e = 24'h000000;
      4'd1:  e = 24'hAA0000;
      4'd2:  e = 24'h00AA00;
      4'd3:  e = 24'hAA5500;
      4'd4:  e = 24'h0000AA;
      4'd5:  e = 24'hAA00AA;
      4'd6:  e = 24'h00AAAA;
      4'd7:  e = 24'hAAAAAA;
      4'd8:  e = 24'h555555;
      4'd9:  e = 24'hFF5555;
      4'd10: e = 24'h55FF55;
      4'd11: e = 24'hFFFF55;
      4'd12: e = 24'h5555FF;
      4'd13: e = 24'hFF55FF;
      4'd14: e = 24'h55FFFF;
      default: e = 24'hFFFFFF;
    endcase
    return e;
  endfunction

  // keep only the low bytes of a pixel
  function automatic logic [31:0] fmt_mask(logic [1:0] fmt);
    logic [31:0] m;
    unique case (pixel_fmt_t'(fmt))
      FMT_8BPP:  m = 32'h0000_00FF;
      FMT_16BPP: m = 32'h0000_FFFF;
      FMT_24BPP: m = 32'h00FF_FFFF;
      FMT_32BPP: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/core/tcgr_color.sv]
// Palette lookup and component packing for one color index; in 8 bpp the index itself is the value.
// Depends on tcgr_pkg.
module tcgr_color (
  input  logic [3:0]   idx,
  input  tcgr_pkg::cfg_t cfg,
  output logic [31:0]  value
);

  function automatic logic [31:0] place_comp(logic [7:0] c, logic [3:0] size,
                                             logic [4:0] pos);
    logic [3:0] s;
    logic [7:0] v;
    s = (size > 4'd8) ? 4'd8 : size;
    v = c >> (4'd8 - s);  // size 0 shifts everything out
    return {24'b0, v} << pos;
  endfunction

  logic [23:0] e;

  always_comb begin
    e = tcgr_pkg::palette(idx);
    if (tcgr_pkg::pixel_fmt_t'(cfg.pixel_format) == tcgr_pkg::FMT_8BPP) begin
      value = {28'b0, idx};
    end else begin
      value = place_comp(e[23:16], cfg.red_size, cfg.red_pos)
            | place_comp(e[15:8], cfg.green_size, cfg.green_pos)
            | place_comp(e[7:0], cfg.blue_size, cfg.blue_pos);
    end
  end

endmodule

[rtl/core/tcgr_prep.sv]
// Input stage: resolves colors, glyph bit order and line base per request.
// Depends on tcgr_pkg and tcgr_color.
module tcgr_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  tcgr_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           cell_row,
  input  logic [7:0]           cell_col,
  input  logic [3:0]           glyph_line,
  input  logic [15:0]          char_attr,
  input  logic [7:0]           glyph_bits,
  input  logic                 invert,
  input  logic                 job_take,
  output logic                 job_valid,
  output tcgr_pkg::job_t       job
);

  logic                             accept;
  logic [3:0]                       fg_idx;
  logic [3:0]                       bg_idx;
  logic [31:0]                      fg_raw;
  logic [31:0]                      bg_raw;
  logic [31:0]                      mask;
  logic [2:0]                       bpp;
  logic [tcgr_pkg::RL_W-1:0]        rl;
  logic [tcgr_pkg::COL_W-1:0]       col_px;
  logic [tcgr_pkg::GLYPH_WIDTH-1:0] on;
  tcgr_pkg::job_t                   job_next;

  assign in_stall = job_valid && !job_take;
  assign accept   = in_valid && !in_stall;

  // invert swaps fg and bg, as for the cursor
  assign fg_idx = invert ? char_attr[15:12] : char_attr[11:8];
  assign bg_idx = invert ? char_attr[11:8]  : char_attr[15:12];

  tcgr_color u_fg (.idx(fg_idx), .cfg(cfg), .value(fg_raw));
  tcgr_color u_bg (.idx(bg_idx), .cfg(cfg), .value(bg_raw));

  always_comb begin
    mask   = tcgr_pkg::fmt_mask(cfg.pixel_format);
    bpp    = {1'b0, cfg.pixel_format} + 3'd1;
    rl     = tcgr_pkg::RL_W'(cell_row) * tcgr_pkg::RL_W'(tcgr_pkg::GLYPH_HEIGHT)
           + tcgr_pkg::RL_W'(glyph_line);
    col_px = tcgr_pkg::COL_W'(cell_col) * tcgr_pkg::COL_W'(tcgr_pkg::GLYPH_WIDTH);
    // pixel k takes glyph bit GLYPH_WIDTH-1-k; bits past the font byte are bg
    on = '0;
    for (int k = 0; k < tcgr_pkg::GLYPH_WIDTH; k++) begin
      if (tcgr_pkg::GLYPH_WIDTH - 1 - k < 8) begin
        on[k] = glyph_bits[3'(tcgr_pkg::GLYPH_WIDTH - 1 - k)];
      end
    end
    job_next.line_base = tcgr_pkg::LB_W'(rl) * tcgr_pkg::LB_W'(cfg.line_pitch);
    job_next.col_off   = tcgr_pkg::CO_W'(col_px) * tcgr_pkg::CO_W'(bpp);
    job_next.bpp       = bpp;
    job_next.fg_val    = fg_raw & mask;
    job_next.bg_val    = bg_raw & mask;
    job_next.on        = on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= accept || (job_valid && !job_take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

[rtl/core/tcgr_emit.sv]
// Pixel sequencer: walks one prepared glyph line, one pixel write per cycle while out_stall is low.
// Depends on tcgr_pkg and the macros header.
`include "text_cell_glyph_renderer_macros.svh"
module tcgr_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  tcgr_pkg::job_t       job,
  output logic                 job_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          byte_offset,
  output logic [31:0]          pixel_value,
  output logic                 last_pixel
);

  localparam logic [tcgr_pkg::K_W-1:0] K_LAST =
    tcgr_pkg::K_W'(tcgr_pkg::GLYPH_WIDTH - 1);

  logic                             adv;
  logic                             step;
  logic [tcgr_pkg::K_W-1:0]         k;
  logic [2:0]                       bpp;
  logic [31:0]                      fg_val;
  logic [31:0]                      bg_val;
  logic [tcgr_pkg::GLYPH_WIDTH-1:0] rem;

  assign adv      = !out_valid || !out_stall;
  assign step     = adv && out_valid && !last_pixel;
  assign job_take = adv && job_valid && (!out_valid || last_pixel);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      k          <= '0;
      last_pixel <= 1'b0;
    end else if (step) begin
      k          <= k + tcgr_pkg::K_W'(1);
      last_pixel <= (k + tcgr_pkg::K_W'(1)) == K_LAST;
    end else if (job_take) begin
      out_valid  <= 1'b1;
      k          <= '0;
      last_pixel <= (K_LAST == '0);
    end else if (adv) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_offset <= byte_offset + {29'b0, bpp};
      pixel_value <= rem[0] ? fg_val : bg_val;
      rem         <= rem >> 1;
    end else if (job_take) begin
      byte_offset <= 32'(job.line_base) + 32'(job.col_off);
      pixel_value <= job.on[0] ? job.fg_val : job.bg_val;
      rem         <= job.on >> 1;
      bpp         <= job.bpp;
      fg_val      <= job.fg_val;
      bg_val      <= job.bg_val;
    end
  end

  `TCGR_ASSERT(a_step_count, clk, rst, step |=> out_valid && k == $past(k) + tcgr_pkg::K_W'(1))
  `TCGR_ASSERT(a_step_offset, clk, rst, step |=> byte_offset == $past(byte_offset) + {29'b0, bpp})
  `TCGR_ASSERT(a_load_first, clk, rst, job_take |=> out_valid && k == '0)
  `TCGR_ASSERT(a_take_idle, clk, rst, job_take |-> !step)

endmodule

[rtl/core/text_cell_glyph_renderer.sv]
// Text cell glyph renderer: one glyph line in, GLYPH_WIDTH pixel writes out.
// An accepted request is registered in the input stage, then loaded into
// the output register of the pixel sequencer, which gives one pixel per
// cycle while out_stall is low.
// Reset (rst, synchronous, active high) empties both stages and restores
// the register defaults: 32 bpp, pitch 4096, 8-bit components at 16/8/0.
module text_cell_glyph_renderer (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // glyph line requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  cell_row,
  input  logic [7:0]  cell_col,
  input  logic [3:0]  glyph_line,
  input  logic [15:0] char_attr,
  input  logic [7:0]  glyph_bits,
  input  logic        invert,
  // pixel writes
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] byte_offset,
  output logic [31:0] pixel_value,
  output logic        last_pixel
);

  tcgr_pkg::cfg_t cfg;
  tcgr_pkg::job_t job;
  logic           job_valid;
  logic           job_take;

  // Register file, no shadowing. Writes must land only while the block is idle;
  // the block does not enforce it. Fields keep the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= 2'd3;
      cfg.line_pitch   <= 16'd4096;
      cfg.red_size     <= 4'd8;
      cfg.red_pos      <= 5'd16;
      cfg.green_size   <= 4'd8;
      cfg.green_pos    <= 5'd8;
      cfg.blue_size    <= 4'd8;
      cfg.blue_pos     <= 5'd0;
    end else if (cfg_write) begin
      unique case (tcgr_pkg::cfg_reg_t'(cfg_index))
        tcgr_pkg::REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[1:0];
        tcgr_pkg::REG_LINE_PITCH:   cfg.line_pitch   <= cfg_data;
        tcgr_pkg::REG_RED_SIZE:     cfg.red_size     <= cfg_data[3:0];
        tcgr_pkg::REG_RED_POS:      cfg.red_pos      <= cfg_data[4:0];
        tcgr_pkg::REG_GREEN_SIZE:   cfg.green_size   <= cfg_data[3:0];
        tcgr_pkg::REG_GREEN_POS:    cfg.green_pos    <= cfg_data[4:0];
        tcgr_pkg::REG_BLUE_SIZE:    cfg.blue_size    <= cfg_data[3:0];
        tcgr_pkg::REG_BLUE_POS:     cfg.blue_pos     <= cfg_data[4:0];
      endcase
    end
  end

  // Stage 1: color lookup, glyph bit order, scan line base multiply.
  // Holds one prepared line, so a new request is taken while the
  // sequencer is still busy with the previous one.
  tcgr_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .glyph_line (glyph_line),
    .char_attr  (char_attr),
    .glyph_bits (glyph_bits),
    .invert     (invert),
    .job_take   (job_take),
    .job_valid  (job_valid),
    .job        (job)
  );

  // Stage 2: steps through the pixels; the next line is loaded on the
  // same edge the last pixel of the current one leaves, so no bubble.
  tcgr_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .job_take    (job_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_offset (byte_offset),
    .pixel_value (pixel_value),
    .last_pixel  (last_pixel)
  );

endmodule
